>>> design/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;

	localparam int SEM_COUNT  = 16;
	localparam int PROC_COUNT = 32;

	localparam int SEM_W  = $clog2(SEM_COUNT);
	localparam int SCNT_W = $clog2(SEM_COUNT + 1);
	localparam int QIDX_W = $clog2(PROC_COUNT);
	localparam int QSZ_W  = $clog2(PROC_COUNT + 1);
	localparam int PROC_W = 5;
	localparam int CNT_W  = 16;
	localparam int ID_W   = 8;
	localparam int ADDR_W = SEM_W + QIDX_W;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_CREATE  = 3'd0;
	localparam kind_t KIND_DOWN    = 3'd1;
	localparam kind_t KIND_UP      = 3'd2;
	localparam kind_t KIND_DESTROY = 3'd3;
	localparam kind_t KIND_CANCEL  = 3'd4;
	localparam kind_t KIND_CLEANUP = 3'd5;

	typedef logic [2:0] code_t;
	localparam code_t CODE_OK          = 3'd0;
	localparam code_t CODE_SUSPEND     = 3'd1;
	localparam code_t CODE_INVALID     = 3'd2;
	localparam code_t CODE_EXISTS      = 3'd3;
	localparam code_t CODE_AGAIN       = 3'd4;
	localparam code_t CODE_OVERFLOW    = 3'd5;
	localparam code_t CODE_REMOVED     = 3'd6;
	localparam code_t CODE_INTERRUPTED = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEM,
		ST_SCAN,
		ST_WAKE,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic latch;
		logic decode;
		logic scan_start;
		logic scan_step;
		logic scan_end;
		logic sem_next;
		logic wake_int;
		logic reply;
	} cmd_t;

	typedef struct packed {
		logic dec_simple;
		logic dec_scan;
		logic dec_sweep;
		logic sweep_kind;
		logic scan_done;
		logic sweep_done;
		logic sem_used;
		logic wake_pending;
	} status_t;

	function automatic logic [QIDX_W-1:0] ring_idx(input logic [QIDX_W-1:0] h,
		input logic [QSZ_W-1:0] i);
		logic [QSZ_W:0] sum;
		sum = {{(QSZ_W + 1 - QIDX_W){1'b0}}, h} + {1'b0, i};
		if (sum >= (QSZ_W + 1)'(PROC_COUNT)) begin
			sum = sum - (QSZ_W + 1)'(PROC_COUNT);
		end
		return sum[QIDX_W-1:0];
	endfunction

endpackage

>>> design/counting_semaphore_table_core.sv
`timescale 1ns / 1ps
// Table of counting semaphores with FIFO wait queues. A command is taken when start is high and
// busy is low. Its results appear on result_valid for one cycle each and cannot be held off:
// wake replies first, then one caller reply with last set. Create and simple down/up are
// answered from decode; down with an empty count, up with waiters and destroy scan the wait
// queue (up reads only its head entry), one entry a cycle through the single queue memory
// read port; cleanup and cancel of a blocked process visit every semaphore, rescan the queue
// of each used semaphore, and cancel then sends the interrupt wake. The next command may be
// started while the last reply is on the ports.
module counting_semaphore_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  kind,
	input  logic [cst_pkg::ID_W-1:0]    sem_id,
	input  logic [cst_pkg::CNT_W-1:0]   init_value,
	input  logic [cst_pkg::PROC_W-1:0]  process,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cst_pkg::CNT_W-1:0]   cfg_data,
	output logic                        result_valid,
	output logic [cst_pkg::PROC_W-1:0]  target_process,
	output logic                        to_caller,
	output logic [2:0]                  code,
	output logic                        last
);

	cst_pkg::cmd_t    cmd;
	cst_pkg::status_t st;

	assign cfg_ready = 1'b1;

	cst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	cst_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.kind           (kind),
		.sem_id         (sem_id),
		.init_value     (init_value),
		.process        (process),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.target_process (target_process),
		.to_caller      (to_caller),
		.code           (code),
		.last           (last)
	);

endmodule

>>> design/cst_ctrl.sv
`timescale 1ns / 1ps
module cst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cst_pkg::status_t st,
	output cst_pkg::cmd_t    cmd
);

	cst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			cst_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = cst_pkg::ST_DECODE;
				end
			end
			cst_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				if (st.dec_scan) begin
					state_d = cst_pkg::ST_SCAN;
				end else if (st.dec_sweep) begin
					state_d = cst_pkg::ST_SEM;
				end else begin
					state_d = cst_pkg::ST_IDLE;
				end
			end
			cst_pkg::ST_SEM: begin
				if (st.sweep_done) begin
					state_d = st.wake_pending ? cst_pkg::ST_WAKE : cst_pkg::ST_REPLY;
				end else if (st.sem_used) begin
					cmd.scan_start = 1'b1;
					state_d        = cst_pkg::ST_SCAN;
				end else begin
					cmd.sem_next = 1'b1;
				end
			end
			cst_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_done) begin
					cmd.scan_end = 1'b1;
					if (st.sweep_kind) begin
						cmd.sem_next = 1'b1;
						state_d      = cst_pkg::ST_SEM;
					end else begin
						state_d = cst_pkg::ST_REPLY;
					end
				end
			end
			cst_pkg::ST_WAKE: begin
				cmd.wake_int = 1'b1;
				state_d      = cst_pkg::ST_REPLY;
			end
			cst_pkg::ST_REPLY: begin
				cmd.reply = 1'b1;
				state_d   = cst_pkg::ST_IDLE;
			end
			default: begin
				state_d = cst_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != cst_pkg::ST_IDLE);

endmodule

>>> design/cst_dp.sv
`timescale 1ns / 1ps
module cst_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cst_pkg::cmd_t               cmd,
	output cst_pkg::status_t            st,
	input  logic [2:0]                  kind,
	input  logic [cst_pkg::ID_W-1:0]    sem_id,
	input  logic [cst_pkg::CNT_W-1:0]   init_value,
	input  logic [cst_pkg::PROC_W-1:0]  process,
	input  logic                        cfg_we,
	input  logic [cst_pkg::CNT_W-1:0]   cfg_data,
	output logic                        result_valid,
	output logic [cst_pkg::PROC_W-1:0]  target_process,
	output logic                        to_caller,
	output logic [2:0]                  code,
	output logic                        last
);

	// configuration
	logic [cst_pkg::CNT_W-1:0] max_q;

	// latched command
	cst_pkg::kind_t             kind_q;
	logic [cst_pkg::ID_W-1:0]   id_q;
	logic [cst_pkg::CNT_W-1:0]  init_q;
	logic [cst_pkg::PROC_W-1:0] proc_q;
	cst_pkg::code_t             reply_code_q;
	logic                       wake_q;

	// semaphore table
	logic                       in_use_q [cst_pkg::SEM_COUNT];
	logic [cst_pkg::CNT_W-1:0]  count_q  [cst_pkg::SEM_COUNT];
	logic [cst_pkg::QIDX_W-1:0] head_q   [cst_pkg::SEM_COUNT];
	logic [cst_pkg::QSZ_W-1:0]  size_q   [cst_pkg::SEM_COUNT];
	logic                       blocked_q [cst_pkg::PROC_COUNT];

	// wait queue memory
	logic [cst_pkg::PROC_W-1:0] mem [2**cst_pkg::ADDR_W];

	// scan engine
	logic [cst_pkg::SCNT_W-1:0] s_q;
	logic [cst_pkg::QSZ_W-1:0]  rd_idx_q;
	logic [cst_pkg::QSZ_W-1:0]  lim_q;
	logic [cst_pkg::QSZ_W-1:0]  wr_n_q;
	logic                       found_q;
	logic                       pend_s1;
	logic [cst_pkg::PROC_W-1:0] rd_data_s1;

	// result register
	logic                       out_valid_q;
	logic [cst_pkg::PROC_W-1:0] out_target_q;
	logic                       out_caller_q;
	cst_pkg::code_t             out_code_q;
	logic                       out_last_q;

	logic                       id_ok;
	logic                       proc_ok;
	logic [cst_pkg::SEM_W-1:0]  s_dec;
	logic [cst_pkg::SEM_W-1:0]  sel;
	logic                       sel_use;
	logic [cst_pkg::CNT_W-1:0]  sel_cnt;
	logic [cst_pkg::QIDX_W-1:0] sel_head;
	logic [cst_pkg::QSZ_W-1:0]  sel_size;
	logic                       mode_dup;
	logic                       mode_drop;
	logic                       mode_pop;
	logic                       dec_simple;
	logic                       dec_scan;
	logic                       dec_sweep;
	cst_pkg::code_t             dec_code;
	logic                       issue;
	logic                       scan_done;
	logic                       mem_we;
	logic [cst_pkg::ADDR_W-1:0] mem_waddr;
	logic [cst_pkg::PROC_W-1:0] mem_wdata;
	logic [cst_pkg::ADDR_W-1:0] mem_raddr;

	assign id_ok   = (id_q >= cst_pkg::ID_W'(1)) && (id_q <= cst_pkg::ID_W'(cst_pkg::SEM_COUNT));
	assign proc_ok = ({1'b0, proc_q} < (cst_pkg::PROC_W + 1)'(cst_pkg::PROC_COUNT));
	assign s_dec   = cst_pkg::SEM_W'(id_q - cst_pkg::ID_W'(1));
	assign sel     = cmd.decode ? s_dec : s_q[cst_pkg::SEM_W-1:0];

	assign sel_use  = in_use_q[sel];
	assign sel_cnt  = count_q[sel];
	assign sel_head = head_q[sel];
	assign sel_size = size_q[sel];

	assign mode_dup  = (kind_q == cst_pkg::KIND_DOWN);
	assign mode_pop  = (kind_q == cst_pkg::KIND_UP) || (kind_q == cst_pkg::KIND_DESTROY);
	assign mode_drop = (kind_q == cst_pkg::KIND_CANCEL) || (kind_q == cst_pkg::KIND_CLEANUP);

	always_comb begin
		dec_simple = 1'b1;
		dec_scan   = 1'b0;
		dec_sweep  = 1'b0;
		dec_code   = cst_pkg::CODE_INVALID;
		case (kind_q)
			cst_pkg::KIND_CREATE: begin
				if (id_ok && init_q <= max_q) begin
					dec_code = sel_use ? cst_pkg::CODE_EXISTS : cst_pkg::CODE_OK;
				end
			end
			cst_pkg::KIND_DOWN: begin
				if (id_ok && sel_use && proc_ok) begin
					if (sel_cnt != '0) begin
						dec_code = cst_pkg::CODE_OK;
					end else if (sel_size >= cst_pkg::QSZ_W'(cst_pkg::PROC_COUNT)) begin
						dec_code = cst_pkg::CODE_AGAIN;
					end else begin
						dec_code   = cst_pkg::CODE_SUSPEND;
						dec_simple = 1'b0;
						dec_scan   = 1'b1;
					end
				end
			end
			cst_pkg::KIND_UP: begin
				if (id_ok && sel_use) begin
					if (sel_size != '0) begin
						dec_code   = cst_pkg::CODE_OK;
						dec_simple = 1'b0;
						dec_scan   = 1'b1;
					end else if (sel_cnt >= max_q) begin
						dec_code = cst_pkg::CODE_OVERFLOW;
					end else begin
						dec_code = cst_pkg::CODE_OK;
					end
				end
			end
			cst_pkg::KIND_DESTROY: begin
				if (id_ok && sel_use) begin
					dec_code   = cst_pkg::CODE_OK;
					dec_simple = 1'b0;
					dec_scan   = 1'b1;
				end
			end
			cst_pkg::KIND_CANCEL: begin
				// a process that is not blocked is left in its queues
				if (proc_ok) begin
					dec_code = cst_pkg::CODE_OK;
					if (blocked_q[proc_q]) begin
						dec_simple = 1'b0;
						dec_sweep  = 1'b1;
					end
				end
			end
			cst_pkg::KIND_CLEANUP: begin
				if (proc_ok) begin
					dec_code   = cst_pkg::CODE_OK;
					dec_simple = 1'b0;
					dec_sweep  = 1'b1;
				end
			end
			default: begin
				dec_code = cst_pkg::CODE_INVALID;
			end
		endcase
	end

	assign issue     = cmd.scan_step && (rd_idx_q < lim_q);
	assign scan_done = (rd_idx_q == lim_q) && !pend_s1;

	assign st.dec_simple   = dec_simple;
	assign st.dec_scan     = dec_scan;
	assign st.dec_sweep    = dec_sweep;
	assign st.sweep_kind   = mode_drop;
	assign st.scan_done    = scan_done;
	assign st.sweep_done   = (s_q == cst_pkg::SCNT_W'(cst_pkg::SEM_COUNT));
	assign st.sem_used     = sel_use;
	assign st.wake_pending = wake_q;

	// memory ports
	assign mem_raddr = {s_q[cst_pkg::SEM_W-1:0], cst_pkg::ring_idx(sel_head, rd_idx_q)};

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rd_data_s1;
		mem_waddr = {s_q[cst_pkg::SEM_W-1:0], cst_pkg::ring_idx(sel_head, wr_n_q)};
		if (cmd.scan_step && pend_s1 && mode_drop && rd_data_s1 != proc_q) begin
			mem_we = 1'b1;
		end else if (cmd.scan_end && mode_dup && !found_q) begin
			mem_we    = 1'b1;
			mem_wdata = proc_q;
			mem_waddr = {s_q[cst_pkg::SEM_W-1:0], cst_pkg::ring_idx(sel_head, sel_size)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			id_q   <= sem_id;
			init_q <= init_value;
			proc_q <= process;
		end
		if (cmd.decode) begin
			reply_code_q <= dec_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= '1;
			s_q      <= '0;
			rd_idx_q <= '0;
			lim_q    <= '0;
			wr_n_q   <= '0;
			found_q  <= 1'b0;
			pend_s1  <= 1'b0;
			wake_q   <= 1'b0;
			for (int i = 0; i < cst_pkg::SEM_COUNT; i++) begin
				in_use_q[i] <= 1'b0;
				count_q[i]  <= '0;
				head_q[i]   <= '0;
				size_q[i]   <= '0;
			end
			for (int i = 0; i < cst_pkg::PROC_COUNT; i++) begin
				blocked_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end

			if (cmd.decode) begin
				if (dec_simple && dec_code == cst_pkg::CODE_OK) begin
					case (kind_q)
						cst_pkg::KIND_CREATE: begin
							in_use_q[sel] <= 1'b1;
							count_q[sel]  <= init_q;
							head_q[sel]   <= '0;
							size_q[sel]   <= '0;
						end
						cst_pkg::KIND_DOWN: begin
							count_q[sel] <= sel_cnt - cst_pkg::CNT_W'(1);
						end
						cst_pkg::KIND_UP: begin
							count_q[sel] <= sel_cnt + cst_pkg::CNT_W'(1);
						end
						default: begin
						end
					endcase
				end
				if (dec_scan) begin
					s_q      <= cst_pkg::SCNT_W'(s_dec);
					rd_idx_q <= '0;
					wr_n_q   <= '0;
					found_q  <= 1'b0;
					pend_s1  <= 1'b0;
					lim_q    <= (kind_q == cst_pkg::KIND_UP) ? cst_pkg::QSZ_W'(1) : sel_size;
				end
				if (dec_sweep) begin
					s_q                <= '0;
					wake_q             <= (kind_q == cst_pkg::KIND_CANCEL) && blocked_q[proc_q];
					blocked_q[proc_q]  <= 1'b0;
				end
			end

			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				wr_n_q   <= '0;
				found_q  <= 1'b0;
				pend_s1  <= 1'b0;
				lim_q    <= sel_size;
			end

			if (cmd.scan_step) begin
				pend_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + cst_pkg::QSZ_W'(1);
				end
				if (pend_s1) begin
					if (mode_dup && rd_data_s1 == proc_q) begin
						found_q <= 1'b1;
					end
					if (mode_drop && rd_data_s1 != proc_q) begin
						wr_n_q <= wr_n_q + cst_pkg::QSZ_W'(1);
					end
					if (mode_pop) begin
						blocked_q[rd_data_s1] <= 1'b0;
					end
				end
			end

			if (cmd.scan_end) begin
				if (mode_dup) begin
					if (!found_q) begin
						size_q[sel] <= sel_size + cst_pkg::QSZ_W'(1);
					end
					blocked_q[proc_q] <= 1'b1;
				end else if (mode_drop) begin
					size_q[sel] <= wr_n_q;
					if (wr_n_q == '0) begin
						head_q[sel] <= '0;
					end
				end else if (kind_q == cst_pkg::KIND_UP) begin
					size_q[sel] <= sel_size - cst_pkg::QSZ_W'(1);
					head_q[sel] <= (sel_size == cst_pkg::QSZ_W'(1)) ? '0 :
						cst_pkg::ring_idx(sel_head, cst_pkg::QSZ_W'(1));
				end else begin
					in_use_q[sel] <= 1'b0;
					count_q[sel]  <= '0;
					head_q[sel]   <= '0;
					size_q[sel]   <= '0;
				end
			end

			if (cmd.sem_next) begin
				s_q <= s_q + cst_pkg::SCNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd.decode && dec_simple) || cmd.reply || cmd.wake_int ||
				(cmd.scan_step && pend_s1 && mode_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode && dec_simple) begin
			out_target_q <= proc_q;
			out_caller_q <= 1'b1;
			out_code_q   <= dec_code;
			out_last_q   <= 1'b1;
		end else if (cmd.reply) begin
			out_target_q <= proc_q;
			out_caller_q <= 1'b1;
			out_code_q   <= reply_code_q;
			out_last_q   <= 1'b1;
		end else if (cmd.wake_int) begin
			out_target_q <= proc_q;
			out_caller_q <= 1'b0;
			out_code_q   <= cst_pkg::CODE_INTERRUPTED;
			out_last_q   <= 1'b0;
		end else if (cmd.scan_step && pend_s1 && mode_pop) begin
			out_target_q <= rd_data_s1;
			out_caller_q <= 1'b0;
			out_code_q   <= (kind_q == cst_pkg::KIND_UP) ? cst_pkg::CODE_OK : cst_pkg::CODE_REMOVED;
			out_last_q   <= 1'b0;
		end
	end

	assign result_valid   = out_valid_q;
	assign target_process = out_target_q;
	assign to_caller      = out_caller_q;
	assign code           = out_code_q;
	assign last           = out_last_q;

	a_last_is_caller: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == out_caller_q))
		else $error("last flag and caller flag disagree");

	a_decode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decode |-> $onehot({dec_simple, dec_scan, dec_sweep}))
		else $error("decode outcome not unique");

	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_end && mode_dup && !found_q) |->
		(sel_size < cst_pkg::QSZ_W'(cst_pkg::PROC_COUNT)))
		else $error("append to a full wait queue");

	a_scan_read_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (rd_idx_q <= lim_q))
		else $error("scan read past queue length");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam cst_pkg::kind_t KIND_BAD6 = 3'd6;
	localparam cst_pkg::kind_t KIND_BAD7 = 3'd7;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [4:0]      target;
		logic            caller;
		cst_pkg::code_t  code_f;
		logic            last_f;
	} reply_t;

	typedef struct {
		cst_pkg::kind_t  k;
		logic [7:0]      id;
		logic [15:0]     iv;
		logic [4:0]      p;
		bit              chk;
		cst_pkg::code_t  want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] kind;
	logic [7:0] sem_id;
	logic [15:0] init_value;
	logic [4:0] process;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;
	logic result_valid;
	logic [4:0] target_process;
	logic to_caller;
	logic [2:0] code;
	logic last;

	counting_semaphore_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.sem_id(sem_id), .init_value(init_value), .process(process),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .target_process(target_process),
		.to_caller(to_caller), .code(code), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [15:0] max_val;
	bit          sem_used [cst_pkg::SEM_COUNT];
	int unsigned sem_cnt [cst_pkg::SEM_COUNT];
	logic [4:0]  ring [cst_pkg::SEM_COUNT][cst_pkg::PROC_COUNT];
	int unsigned q_head [cst_pkg::SEM_COUNT];
	int unsigned q_size [cst_pkg::SEM_COUNT];
	bit          proc_blocked [cst_pkg::PROC_COUNT];

	reply_t pending_replies[$];
	int err_count = 0;
	int cmds_sent = 0;
	int replies_seen = 0;
	int wakes_seen = 0;
	int idle_cycles = 0;
	int gap_pct = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	function automatic logic [4:0] pop_waiter(input int s);
		logic [4:0] w;
		w = ring[s][q_head[s] % cst_pkg::PROC_COUNT];
		q_head[s] = (q_head[s] + 1) % cst_pkg::PROC_COUNT;
		q_size[s]--;
		if (q_size[s] == 0) q_head[s] = 0;
		return w;
	endfunction

	function automatic void drop_all(input logic [4:0] p);
		logic [4:0] keep [cst_pkg::PROC_COUNT];
		int n;
		for (int s = 0; s < cst_pkg::SEM_COUNT; s++) begin
			if (sem_used[s]) begin
				n = 0;
				for (int i = 0; i < q_size[s]; i++) begin
					if (ring[s][(q_head[s] + i) % cst_pkg::PROC_COUNT] != p) begin
						keep[n] = ring[s][(q_head[s] + i) % cst_pkg::PROC_COUNT];
						n++;
					end
				end
				for (int i = 0; i < n; i++) ring[s][i] = keep[i];
				q_head[s] = 0;
				q_size[s] = n;
			end
		end
		proc_blocked[p] = 1'b0;
	endfunction

	function automatic void predict_command(input cst_pkg::kind_t k, input logic [7:0] id,
		input logic [15:0] iv, input logic [4:0] p);
		int s;
		bit id_ok;
		bit found;
		cst_pkg::code_t c;
		logic [4:0] w;
		c = cst_pkg::CODE_INVALID;
		id_ok = id >= 1 && id <= cst_pkg::SEM_COUNT;
		s = id_ok ? id - 1 : 0;
		case (k)
			cst_pkg::KIND_CREATE: begin
				if (id_ok && iv <= max_val) begin
					if (sem_used[s]) c = cst_pkg::CODE_EXISTS;
					else begin
						sem_used[s] = 1'b1;
						sem_cnt[s] = iv;
						q_head[s] = 0;
						q_size[s] = 0;
						c = cst_pkg::CODE_OK;
					end
				end
			end
			cst_pkg::KIND_DOWN: begin
				if (id_ok && sem_used[s]) begin
					if (sem_cnt[s] > 0) begin
						sem_cnt[s]--;
						c = cst_pkg::CODE_OK;
					end else if (q_size[s] >= cst_pkg::PROC_COUNT) c = cst_pkg::CODE_AGAIN;
					else begin
						found = 1'b0;
						for (int i = 0; i < q_size[s]; i++)
							if (ring[s][(q_head[s] + i) % cst_pkg::PROC_COUNT] == p)
								found = 1'b1;
						if (!found) begin
							ring[s][(q_head[s] + q_size[s]) % cst_pkg::PROC_COUNT] = p;
							q_size[s]++;
						end
						proc_blocked[p] = 1'b1;
						c = cst_pkg::CODE_SUSPEND;
					end
				end
			end
			cst_pkg::KIND_UP: begin
				if (id_ok && sem_used[s]) begin
					if (q_size[s] > 0) begin
						w = pop_waiter(s);
						proc_blocked[w] = 1'b0;
						pending_replies.push_back('{w, 1'b0, cst_pkg::CODE_OK, 1'b0});
						c = cst_pkg::CODE_OK;
					end else if (sem_cnt[s] >= max_val) c = cst_pkg::CODE_OVERFLOW;
					else begin
						sem_cnt[s]++;
						c = cst_pkg::CODE_OK;
					end
				end
			end
			cst_pkg::KIND_DESTROY: begin
				if (id_ok && sem_used[s]) begin
					while (q_size[s] > 0) begin
						w = pop_waiter(s);
						proc_blocked[w] = 1'b0;
						pending_replies.push_back('{w, 1'b0, cst_pkg::CODE_REMOVED, 1'b0});
					end
					sem_used[s] = 1'b0;
					sem_cnt[s] = 0;
					q_head[s] = 0;
					c = cst_pkg::CODE_OK;
				end
			end
			cst_pkg::KIND_CANCEL: begin
				if (proc_blocked[p]) begin
					drop_all(p);
					pending_replies.push_back('{p, 1'b0, cst_pkg::CODE_INTERRUPTED, 1'b0});
				end
				c = cst_pkg::CODE_OK;
			end
			cst_pkg::KIND_CLEANUP: begin
				drop_all(p);
				c = cst_pkg::CODE_OK;
			end
			default: c = cst_pkg::CODE_INVALID;
		endcase
		pending_replies.push_back('{p, 1'b1, c, 1'b1});
	endfunction

	task automatic send_command(input cmd_row_t r);
		start <= 1'b1;
		kind <= r.k;
		sem_id <= r.id;
		init_value <= r.iv;
		process <= r.p;
		do @(posedge clk); while (busy);
		predict_command(r.k, r.id, r.iv, r.p);
		if (r.chk) pending_replies[pending_replies.size() - 1].code_f = r.want;
		cmds_sent++;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_and_configure(input logic [15:0] v);
		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_val = v;
	endtask

	function automatic cmd_row_t random_command();
		cmd_row_t r;
		int x;
		x = $urandom_range(99);
		if (x < 20) r.k = cst_pkg::KIND_CREATE;
		else if (x < 50) r.k = cst_pkg::KIND_DOWN;
		else if (x < 72) r.k = cst_pkg::KIND_UP;
		else if (x < 82) r.k = cst_pkg::KIND_DESTROY;
		else if (x < 90) r.k = cst_pkg::KIND_CANCEL;
		else if (x < 96) r.k = cst_pkg::KIND_CLEANUP;
		else r.k = x[0] ? KIND_BAD6 : KIND_BAD7;
		x = $urandom_range(99);
		if (x < 70) r.id = 8'($urandom_range(1, 4));
		else if (x < 92) r.id = 8'($urandom_range(1, cst_pkg::SEM_COUNT));
		else r.id = 8'($urandom_range(0, 255));
		r.iv = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
		r.p = $urandom_range(1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
		r.chk = 1'b0;
		r.want = cst_pkg::CODE_OK;
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && result_valid) begin
			replies_seen++;
			if (!to_caller) wakes_seen++;
			if (pending_replies.size() == 0) begin
				$display("unexpected reply at %0t to process %0d", $time, target_process);
				err_count++;
			end else begin
				e = pending_replies.pop_front();
				if (target_process !== e.target) report("target_process", target_process, e.target);
				if (to_caller !== e.caller) report("to_caller", to_caller, e.caller);
				if (code !== e.code_f) report("code", code, e.code_f);
				if (last !== e.last_f) report("last", last, e.last_f);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	cmd_row_t directed [] = '{
		'{cst_pkg::KIND_UP, 8'd1, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_INVALID},
		'{cst_pkg::KIND_CREATE, 8'd0, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_INVALID},
		'{cst_pkg::KIND_CREATE, 8'd17, 16'd0, 5'd1, 1'b1, cst_pkg::CODE_INVALID},
		'{cst_pkg::KIND_CREATE, 8'd255, 16'd0, 5'd2, 1'b1, cst_pkg::CODE_INVALID},
		'{KIND_BAD6, 8'd1, 16'd0, 5'd3, 1'b1, cst_pkg::CODE_INVALID},
		'{KIND_BAD7, 8'd1, 16'd0, 5'd4, 1'b1, cst_pkg::CODE_INVALID},
		'{cst_pkg::KIND_CREATE, 8'd1, 16'd65535, 5'd31, 1'b1, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_CREATE, 8'd1, 16'd5, 5'd0, 1'b1, cst_pkg::CODE_EXISTS},
		'{cst_pkg::KIND_UP, 8'd1, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_OVERFLOW},
		'{cst_pkg::KIND_CREATE, 8'd16, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DOWN, 8'd16, 16'd0, 5'd31, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DOWN, 8'd16, 16'd0, 5'd31, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DOWN, 8'd16, 16'd0, 5'd0, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_CANCEL, 8'd0, 16'd0, 5'd31, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_CANCEL, 8'd0, 16'd0, 5'd31, 1'b1, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_UP, 8'd16, 16'd0, 5'd9, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DOWN, 8'd16, 16'd0, 5'd5, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DOWN, 8'd16, 16'd0, 5'd6, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_CLEANUP, 8'd0, 16'd0, 5'd5, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DESTROY, 8'd16, 16'd0, 5'd7, 1'b0, cst_pkg::CODE_OK},
		'{cst_pkg::KIND_DESTROY, 8'd16, 16'd0, 5'd7, 1'b1, cst_pkg::CODE_INVALID},
		'{cst_pkg::KIND_DOWN, 8'd2, 16'd0, 5'd7, 1'b1, cst_pkg::CODE_INVALID},
		'{cst_pkg::KIND_CREATE, 8'd3, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_OK}
	};

	initial begin
		cmd_row_t r;
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= cst_pkg::KIND_CREATE;
		sem_id <= '0;
		init_value <= '0;
		process <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		max_val = 16'hFFFF;
		for (int s = 0; s < cst_pkg::SEM_COUNT; s++) begin
			sem_used[s] = 1'b0;
			sem_cnt[s] = 0;
			q_head[s] = 0;
			q_size[s] = 0;
		end
		for (int i = 0; i < cst_pkg::PROC_COUNT; i++) proc_blocked[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_command(directed[i]);
		// fill a wait queue, overrun it, then destroy with every waiter woken
		for (int p = 0; p < cst_pkg::PROC_COUNT; p++)
			send_command('{cst_pkg::KIND_DOWN, 8'd3, 16'd0, 5'(p), 1'b0, cst_pkg::CODE_OK});
		send_command('{cst_pkg::KIND_DOWN, 8'd3, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_AGAIN});
		send_command('{cst_pkg::KIND_DESTROY, 8'd3, 16'd0, 5'd0, 1'b1, cst_pkg::CODE_OK});

		drain_and_configure(16'd3);
		gap_pct = 10;
		repeat (170) send_command(random_command());
		drain_and_configure(16'hFFFF);
		gap_pct = 52;
		repeat (170) send_command(random_command());
		drain_and_configure(16'd1);
		gap_pct = 0;
		repeat (170) send_command(random_command());

		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("commands accepted: %0d, replies checked: %0d (wake replies %0d)",
			cmds_sent, replies_seen, wakes_seen);
		$display("limits 65535, 3 and 1 applied across three pacing phases; mismatches: %0d",
			err_count);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
